FILE: hw/rtl/plsub_pkg.sv
// Shared types and constants of the plasma rectangle subdivider.
// Used by the controller, datapath and top level; no dependencies.
`timescale 1ns / 1ps
package plsub_pkg;
	localparam int MAX_WIDTH  = 512;
	localparam int MAX_HEIGHT = 512;
	localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W     = $clog2(DEPTH);
	localparam int CRD_W      = 9;
	localparam int PIX_W      = 16;
	localparam int RND_W      = 15;

	// configuration register indexes
	localparam logic [2:0] CFG_ROUGHNESS = 3'd0;
	localparam logic [2:0] CFG_SHIFT     = 3'd1;
	localparam logic [2:0] CFG_CEILING   = 3'd2;
	localparam logic [2:0] CFG_BORDER_EN = 3'd3;
	localparam logic [2:0] CFG_BORDER_V  = 3'd4;
	localparam logic [2:0] CFG_WIDTH     = 3'd5;
	localparam logic [2:0] CFG_HEIGHT    = 3'd6;

	// frame store address sources
	localparam logic [2:0] SEL_MID    = 3'd0;
	localparam logic [2:0] SEL_CORN_A = 3'd1;
	localparam logic [2:0] SEL_CORN_B = 3'd2;
	localparam logic [2:0] SEL_CENTER = 3'd3;
	localparam logic [2:0] SEL_SEED   = 3'd4;

	// write value sources
	localparam logic [1:0] VAL_FILL   = 2'd0;
	localparam logic [1:0] VAL_CENTER = 2'd1;
	localparam logic [1:0] VAL_SEED   = 2'd2;

	localparam logic [0:0] OP_SEED = 1'b0;

	typedef struct packed {
		logic       load;
		logic       rd_en;
		logic [2:0] addr_sel;
		logic       cap_a;
		logic       cap_b;
		logic       mul1;
		logic       mul2;
		logic       push;
		logic [1:0] val_sel;
		logic       sum_add;
		logic       finish;
		logic [1:0] mid_idx;
	} cmd_t;

	typedef struct packed {
		logic clr_busy;
		logic op;
		logic small_rect;
		logic q_zero;
		logic can_push;
		logic pend_v;
	} sts_t;
endpackage

FILE: hw/rtl/plasma_rectangle_subdivide_top.sv
// Top level of the plasma rectangle subdivider.
// Depends on plsub_pkg, plsub_ctrl and plsub_datapath.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid/in_ready) takes one command beat: op 0 writes a
//   seed pixel at (left_x, top_y); op 1 subdivides the rectangle given by the
//   four coordinates, filling unset edge midpoints (top, right, bottom, left)
//   and then the centre if it is unset.
//   Output channel (out_valid/out_ready) returns one beat per pixel written;
//   last_write marks the final beat of a command. A command that writes
//   nothing returns no beat.
//   Sequence: a seed writes its one pixel. A subdivide reads each midpoint in
//   turn; an unset one has its two corners read, its displacement multiplied
//   out and its value written. Every midpoint value goes into the centre sum;
//   the centre is then read and written if unset, and the command closes.
//   A rectangle too small to split writes nothing. The single frame-store
//   port, with registered read data, takes every read and write in turn.
//   The last beat of a command appears at the edge where the command closes,
//   since each beat is held back until the next one shows whether it is last.
//   Reset: a pass clears all 262144 pixels of the frame store, one pixel a
//   cycle; in_ready stays low until it ends. Config writes (cfg_we, cfg_index,
//   cfg_data) are taken at any time and must come only while the block is idle.
//   Stall: when out_ready is low with one beat waiting in the output register
//   and one more in the pending slot, the sequencer holds at its next write.
module plasma_rectangle_subdivide_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        op,
	input  logic [8:0]  left_x,
	input  logic [8:0]  top_y,
	input  logic [8:0]  right_x,
	input  logic [8:0]  bottom_y,
	input  logic [3:0]  depth_level,
	input  logic [14:0] rnd_top,
	input  logic [14:0] rnd_right,
	input  logic [14:0] rnd_bottom,
	input  logic [14:0] rnd_left,
	input  logic [15:0] seed_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [8:0]  pixel_x,
	output logic [8:0]  pixel_y,
	output logic [15:0] pixel_value,
	output logic        last_write
);
	plsub_pkg::cmd_t cmd;
	plsub_pkg::sts_t sts;

	// sequencer: one command at a time, one frame-store access per step
	plsub_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// storage, arithmetic and result buffering
	plsub_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.op          (op),
		.left_x      (left_x),
		.top_y       (top_y),
		.right_x     (right_x),
		.bottom_y    (bottom_y),
		.depth_level (depth_level),
		.rnd_top     (rnd_top),
		.rnd_right   (rnd_right),
		.rnd_bottom  (rnd_bottom),
		.rnd_left    (rnd_left),
		.seed_value  (seed_value),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.pixel_value (pixel_value),
		.last_write  (last_write)
	);
endmodule

FILE: hw/rtl/plsub_ram.sv
// Single-port frame store RAM with registered read data.
// Generic; no package dependency.
`timescale 1ns / 1ps
module plsub_ram #(
	parameter int DEPTH  = 262144,
	parameter int DATA_W = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [DATA_W-1:0]        wdata,
	output logic [DATA_W-1:0]        rdata
);
	logic [DATA_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end
endmodule

FILE: hw/rtl/plsub_ctrl.sv
// Sequencer of the subdivider: walks seed, midpoint and centre steps.
// Depends on plsub_pkg; drives plsub_datapath through cmd_t.
`timescale 1ns / 1ps
module plsub_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  plsub_pkg::sts_t sts,
	output plsub_pkg::cmd_t cmd
);
	localparam logic [3:0] ST_CLR   = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_SEED  = 4'd2;
	localparam logic [3:0] ST_RD_P  = 4'd3;
	localparam logic [3:0] ST_CHK_P = 4'd4;
	localparam logic [3:0] ST_RD_B  = 4'd5;
	localparam logic [3:0] ST_MUL1  = 4'd6;
	localparam logic [3:0] ST_MUL2  = 4'd7;
	localparam logic [3:0] ST_FILL  = 4'd8;
	localparam logic [3:0] ST_RD_C  = 4'd9;
	localparam logic [3:0] ST_CHK_C = 4'd10;
	localparam logic [3:0] ST_CTR   = 4'd11;
	localparam logic [3:0] ST_DONE  = 4'd12;

	logic [3:0] state_q, state_d;
	logic [1:0] k_q, k_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			k_q     <= 2'd0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		k_d          = k_q;
		in_ready     = 1'b0;
		cmd          = '0;
		cmd.mid_idx  = k_q;
		cmd.addr_sel = plsub_pkg::SEL_MID;
		cmd.val_sel  = plsub_pkg::VAL_FILL;
		case (state_q)
			ST_CLR: begin
				if (!sts.clr_busy) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					k_d      = 2'd0;
					state_d  = ST_RD_P;
				end
			end
			ST_RD_P: begin
				// sort out seed and tiny rectangles, else read the current midpoint
				if (sts.op == plsub_pkg::OP_SEED) begin
					state_d = ST_SEED;
				end else if (sts.small_rect) begin
					state_d = ST_IDLE;
				end else begin
					cmd.rd_en = 1'b1;
					state_d   = ST_CHK_P;
				end
			end
			ST_CHK_P: begin
				if (!sts.q_zero) begin
					cmd.sum_add = 1'b1;
					k_d         = k_q + 2'd1;
					state_d     = (k_q == 2'd3) ? ST_RD_C : ST_RD_P;
				end else begin
					cmd.rd_en    = 1'b1;
					cmd.addr_sel = plsub_pkg::SEL_CORN_A;
					state_d      = ST_RD_B;
				end
			end
			ST_RD_B: begin
				cmd.cap_a    = 1'b1;
				cmd.rd_en    = 1'b1;
				cmd.addr_sel = plsub_pkg::SEL_CORN_B;
				state_d      = ST_MUL1;
			end
			ST_MUL1: begin
				cmd.cap_b = 1'b1;
				cmd.mul1  = 1'b1;
				state_d   = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = ST_FILL;
			end
			ST_FILL: begin
				if (sts.can_push) begin
					cmd.push = 1'b1;
					k_d      = k_q + 2'd1;
					state_d  = (k_q == 2'd3) ? ST_RD_C : ST_RD_P;
				end
			end
			ST_RD_C: begin
				cmd.rd_en    = 1'b1;
				cmd.addr_sel = plsub_pkg::SEL_CENTER;
				state_d      = ST_CHK_C;
			end
			ST_CHK_C: begin
				state_d = sts.q_zero ? ST_CTR : ST_DONE;
			end
			ST_CTR: begin
				cmd.addr_sel = plsub_pkg::SEL_CENTER;
				cmd.val_sel  = plsub_pkg::VAL_CENTER;
				if (sts.can_push) begin
					cmd.push = 1'b1;
					state_d  = ST_DONE;
				end
			end
			ST_SEED: begin
				cmd.addr_sel = plsub_pkg::SEL_SEED;
				cmd.val_sel  = plsub_pkg::VAL_SEED;
				if (sts.can_push) begin
					cmd.push = 1'b1;
					state_d  = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!sts.pend_v) begin
					state_d = ST_IDLE;
				end else if (sts.can_push) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

FILE: hw/rtl/plsub_datapath.sv
// Datapath: config registers, frame store, displacement arithmetic,
// pending write and output register. Depends on plsub_pkg and plsub_ram.
`timescale 1ns / 1ps
module plsub_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [2:0]                     cfg_index,
	input  logic [15:0]                    cfg_data,
	input  logic                           op,
	input  logic [plsub_pkg::CRD_W-1:0]    left_x,
	input  logic [plsub_pkg::CRD_W-1:0]    top_y,
	input  logic [plsub_pkg::CRD_W-1:0]    right_x,
	input  logic [plsub_pkg::CRD_W-1:0]    bottom_y,
	input  logic [3:0]                     depth_level,
	input  logic [plsub_pkg::RND_W-1:0]    rnd_top,
	input  logic [plsub_pkg::RND_W-1:0]    rnd_right,
	input  logic [plsub_pkg::RND_W-1:0]    rnd_bottom,
	input  logic [plsub_pkg::RND_W-1:0]    rnd_left,
	input  logic [plsub_pkg::PIX_W-1:0]    seed_value,
	input  plsub_pkg::cmd_t                cmd,
	output plsub_pkg::sts_t                sts,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [plsub_pkg::CRD_W-1:0]    pixel_x,
	output logic [plsub_pkg::CRD_W-1:0]    pixel_y,
	output logic [plsub_pkg::PIX_W-1:0]    pixel_value,
	output logic                           last_write
);
	localparam int AW = plsub_pkg::ADDR_W;
	localparam int CW = plsub_pkg::CRD_W;
	localparam int PW = plsub_pkg::PIX_W;
	localparam int RW = plsub_pkg::RND_W;

	// configuration
	logic [9:0]    rough_q;
	logic [4:0]    shift_q;
	logic [PW-1:0] ceil_q;
	logic          bord_en_q;
	logic [PW-1:0] bord_v_q;
	logic [9:0]    width_q, height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rough_q   <= 10'd0;
			shift_q   <= 5'd18;
			ceil_q    <= 16'd255;
			bord_en_q <= 1'b0;
			bord_v_q  <= 16'd0;
			width_q   <= 10'd512;
			height_q  <= 10'd512;
		end else if (cfg_we) begin
			case (cfg_index)
				plsub_pkg::CFG_ROUGHNESS: rough_q   <= cfg_data[9:0];
				plsub_pkg::CFG_SHIFT:     shift_q   <= cfg_data[4:0];
				plsub_pkg::CFG_CEILING:   ceil_q    <= cfg_data;
				plsub_pkg::CFG_BORDER_EN: bord_en_q <= cfg_data[0];
				plsub_pkg::CFG_BORDER_V:  bord_v_q  <= cfg_data;
				plsub_pkg::CFG_WIDTH:     width_q   <= cfg_data[9:0];
				plsub_pkg::CFG_HEIGHT:    height_q  <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	// captured item
	logic          op_q;
	logic [CW-1:0] x1_q, y1_q, x2_q, y2_q;
	logic [3:0]    lvl_q;
	logic [RW-1:0] rnd_q [4];
	logic [PW-1:0] seed_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= op;
			x1_q     <= left_x;
			y1_q     <= top_y;
			x2_q     <= right_x;
			y2_q     <= bottom_y;
			lvl_q    <= depth_level;
			rnd_q[0] <= rnd_top;
			rnd_q[1] <= rnd_right;
			rnd_q[2] <= rnd_bottom;
			rnd_q[3] <= rnd_left;
			seed_q   <= seed_value;
		end
	end

	logic [CW:0]   xsum, ysum;
	logic [CW-1:0] mx, my;
	logic signed [CW+1:0] dx, dy;
	assign xsum = {1'b0, x1_q} + {1'b0, x2_q};
	assign ysum = {1'b0, y1_q} + {1'b0, y2_q};
	assign mx   = xsum[CW:1];
	assign my   = ysum[CW:1];
	assign dx   = $signed({2'b00, x2_q}) - $signed({2'b00, x1_q});
	assign dy   = $signed({2'b00, y2_q}) - $signed({2'b00, y1_q});

	// address selection
	logic [CW-1:0] sx, sy;
	always_comb begin
		sx = mx;
		sy = my;
		case (cmd.addr_sel)
			plsub_pkg::SEL_MID: begin
				case (cmd.mid_idx)
					2'd0:    begin sx = mx;   sy = y1_q; end
					2'd1:    begin sx = x2_q; sy = my;   end
					2'd2:    begin sx = mx;   sy = y2_q; end
					default: begin sx = x1_q; sy = my;   end
				endcase
			end
			plsub_pkg::SEL_CORN_A: begin
				case (cmd.mid_idx)
					2'd0:    begin sx = x1_q; sy = y1_q; end
					2'd1:    begin sx = x2_q; sy = y1_q; end
					2'd2:    begin sx = x1_q; sy = y2_q; end
					default: begin sx = x1_q; sy = y1_q; end
				endcase
			end
			plsub_pkg::SEL_CORN_B: begin
				case (cmd.mid_idx)
					2'd0:    begin sx = x2_q; sy = y1_q; end
					2'd1:    begin sx = x2_q; sy = y2_q; end
					2'd2:    begin sx = x2_q; sy = y2_q; end
					default: begin sx = x1_q; sy = y2_q; end
				endcase
			end
			plsub_pkg::SEL_SEED: begin sx = x1_q; sy = y1_q; end
			default: begin sx = mx; sy = my; end
		endcase
	end

	logic          in_store;
	logic [AW-1:0] pix_addr;
	assign in_store = (32'(sx) < plsub_pkg::MAX_WIDTH) && (32'(sy) < plsub_pkg::MAX_HEIGHT);
	assign pix_addr = AW'(AW'(sy) * AW'(plsub_pkg::MAX_WIDTH) + AW'(sx));

	// clearing pass after reset
	logic          clr_busy_q;
	logic [AW-1:0] clr_cnt_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clr_busy_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == AW'(plsub_pkg::DEPTH - 1)) clr_busy_q <= 1'b0;
		end
	end

	// value to store
	logic [PW-1:0] wr_val;
	logic          on_edge;
	logic [PW-1:0] st_val;
	logic [PW-1:0] fill_v;
	logic [17:0]   sum_q;
	logic [17:0]   ctr_sum;
	assign ctr_sum = sum_q + 18'd2;
	always_comb begin
		case (cmd.val_sel)
			plsub_pkg::VAL_FILL:   wr_val = fill_v;
			plsub_pkg::VAL_CENTER: wr_val = ctr_sum[17:2];
			default:               wr_val = seed_q;
		endcase
		on_edge = (sx == '0) || (sy == '0) ||
		          (({1'b0, sx} + 10'd1) == width_q) || (({1'b0, sy} + 10'd1) == height_q);
		st_val  = (bord_en_q && on_edge) ? bord_v_q : wr_val;
		if (st_val == '0) st_val = 16'd1;
	end

	logic          mem_we;
	logic [AW-1:0] mem_addr;
	logic [PW-1:0] mem_wdata, mem_q;
	assign mem_we    = clr_busy_q || (cmd.push && in_store);
	assign mem_addr  = clr_busy_q ? clr_cnt_q : pix_addr;
	assign mem_wdata = clr_busy_q ? '0 : st_val;

	plsub_ram #(.DEPTH(plsub_pkg::DEPTH), .DATA_W(PW)) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.re    (cmd.rd_en),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_q)
	);

	logic          oob_q;
	logic [PW-1:0] rdat;
	always_ff @(posedge clk) begin
		if (cmd.rd_en) oob_q <= !in_store;
	end
	assign rdat = oob_q ? '0 : mem_q;

	// displacement: roughness * (rnd - 16383), then * (320 >> level), floor shift
	logic [PW-1:0]        a_q, b_q;
	logic signed [26:0]   m1_q;
	logic signed [37:0]   d_q;
	logic signed [15:0]   rnd_off;
	logic [8:0]           scale;
	logic signed [37:0]   m2;
	assign rnd_off = $signed({1'b0, rnd_q[cmd.mid_idx]}) - 16'sd16383;
	assign scale   = 9'(10'd320 >> lvl_q);
	assign m2      = 38'(m1_q * $signed({1'b0, scale}));

	logic [PW:0]          ab_sum;
	logic signed [39:0]   fill_raw;
	assign ab_sum   = {1'b0, a_q} + {1'b0, b_q} + 17'd1;
	assign fill_raw = $signed({24'd0, ab_sum[PW:1]}) + 40'(d_q);
	always_comb begin
		if (fill_raw > $signed({24'd0, ceil_q})) fill_v = ceil_q;
		else if (fill_raw < 40'sd1)              fill_v = 16'd1;
		else                                     fill_v = fill_raw[PW-1:0];
		if (fill_v == '0) fill_v = 16'd1;
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_a) a_q <= rdat;
		if (cmd.cap_b) b_q <= rdat;
		if (cmd.mul1)  m1_q <= 27'($signed({1'b0, rough_q}) * rnd_off);
		if (cmd.mul2)  d_q <= m2 >>> shift_q;
		if (cmd.load) begin
			sum_q <= '0;
		end else if (cmd.sum_add) begin
			sum_q <= sum_q + 18'(rdat);
		end else if (cmd.push && cmd.val_sel == plsub_pkg::VAL_FILL) begin
			sum_q <= sum_q + 18'(fill_v);
		end
	end

	// pending write and output register
	logic          pend_v_q, out_v_q;
	logic [CW-1:0] pend_x_q, pend_y_q;
	logic [PW-1:0] pend_val_q;
	logic          out_free;
	assign out_free = !out_v_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (cmd.push) pend_v_q <= 1'b1;
			else if (cmd.finish) pend_v_q <= 1'b0;
			if ((cmd.push && pend_v_q) || cmd.finish) out_v_q <= 1'b1;
			else if (out_ready) out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			pend_x_q   <= sx;
			pend_y_q   <= sy;
			pend_val_q <= st_val;
		end
		if ((cmd.push && pend_v_q) || cmd.finish) begin
			pixel_x     <= pend_x_q;
			pixel_y     <= pend_y_q;
			pixel_value <= pend_val_q;
			last_write  <= cmd.finish;
		end
	end

	assign out_valid      = out_v_q;
	assign sts.clr_busy   = clr_busy_q;
	assign sts.op         = op_q;
	assign sts.small_rect = (dx < 11'sd2) && (dy < 11'sd2);
	assign sts.q_zero     = (rdat == '0);
	assign sts.can_push   = !pend_v_q || out_free;
	assign sts.pend_v     = pend_v_q;
endmodule

FILE: verif/tb_plasma_rectangle_subdivide_top.sv
// Self-checking testbench for plasma_rectangle_subdivide_top: seed and subdivide
// beats with random idling on both channels, checked against a local frame model.
// Depends on plsub_pkg and the RTL of the subdivider.
`timescale 1ns / 1ps
module tb_plasma_rectangle_subdivide_top;
	localparam int RUN_LIMIT   = 1500000;
	localparam int DRAIN_WAIT  = 60;
	localparam logic [0:0] OP_SPLIT = 1'b1;

	typedef struct {
		logic [0:0]  op;
		logic [8:0]  lx, ty, rx, by;
		logic [3:0]  lvl;
		logic [14:0] rt, rr, rb, rl;
		logic [15:0] seed;
	} cmd_beat_t;

	typedef struct {
		logic [8:0]  x, y;
		logic [15:0] v;
		logic        last;
	} pix_beat_t;

	logic        clk, arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        in_valid, in_ready;
	logic        op;
	logic [8:0]  left_x, top_y, right_x, bottom_y;
	logic [3:0]  depth_level;
	logic [14:0] rnd_top, rnd_right, rnd_bottom, rnd_left;
	logic [15:0] seed_value;
	logic        out_valid, out_ready;
	logic [8:0]  pixel_x, pixel_y;
	logic [15:0] pixel_value;
	logic        last_write;

	plasma_rectangle_subdivide_top dut (.*);

	// local copy of the frame and the registers
	bit [15:0] frame_px [0:plsub_pkg::DEPTH-1];
	int rough_r, shift_r, ceil_r, bord_en_r, bord_v_r, width_r, height_r;

	cmd_beat_t pending_cmds[$];
	pix_beat_t expected_px[$];
	int  errors = 0;
	int  cycles = 0;
	bit  in_taken = 0, out_taken = 0;
	int  send_gap = 0, recv_stall = 0;
	bit  send_quiet = 0, recv_quiet = 0;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	task automatic report(input string what);
		$display("[%0t] mismatch: %s", $time, what);
		errors++;
	endtask

	function automatic int read_px(int x, int y);
		if (x < 0 || y < 0 || x >= plsub_pkg::MAX_WIDTH || y >= plsub_pkg::MAX_HEIGHT)
			return 0;
		return frame_px[y * plsub_pkg::MAX_WIDTH + x];
	endfunction

	// store one pixel, apply border replacement, queue its beat
	function automatic void store_px(int x, int y, int v);
		pix_beat_t b;
		if (bord_en_r != 0 && (x == 0 || y == 0 || x == width_r - 1 || y == height_r - 1))
			v = bord_v_r;
		v = v & 16'hFFFF;
		if (v < 1)
			v = 1;
		if (x >= 0 && y >= 0 && x < plsub_pkg::MAX_WIDTH && y < plsub_pkg::MAX_HEIGHT)
			frame_px[y * plsub_pkg::MAX_WIDTH + x] = v[15:0];
		b.x = x[8:0];
		b.y = y[8:0];
		b.v = v[15:0];
		b.last = 1'b0;
		expected_px.push_back(b);
	endfunction

	// midpoint value: stored one if set, else corner mean plus displacement
	function automatic int fill_mid(int xa, int ya, int x, int y, int xb, int yb,
			int rnd, int lvl, ref int n);
		longint d, v;
		int cur;
		cur = read_px(x, y);
		if (cur != 0)
			return cur;
		d = longint'(rough_r) * (longint'(rnd) - 16383) * longint'(320 >> lvl);
		d = d >>> shift_r;
		v = ((longint'(read_px(xa, ya)) + longint'(read_px(xb, yb)) + 1) >> 1) + d;
		if (v > ceil_r)
			v = ceil_r;
		if (v < 1)
			v = 1;
		store_px(x, y, int'(v));
		n++;
		return int'(v);
	endfunction

	function automatic void predict_writes(cmd_beat_t c);
		int n, x1, y1, x2, y2, mx, my, sum;
		n = 0;
		x1 = c.lx; y1 = c.ty; x2 = c.rx; y2 = c.by;
		if (c.op == plsub_pkg::OP_SEED) begin
			store_px(x1, y1, c.seed);
			n = 1;
		end else if (!(x2 - x1 < 2 && y2 - y1 < 2)) begin
			mx = (x1 + x2) >>> 1;
			my = (y1 + y2) >>> 1;
			sum = fill_mid(x1, y1, mx, y1, x2, y1, c.rt, c.lvl, n);
			sum += fill_mid(x2, y1, x2, my, x2, y2, c.rr, c.lvl, n);
			sum += fill_mid(x1, y2, mx, y2, x2, y2, c.rb, c.lvl, n);
			sum += fill_mid(x1, y1, x1, my, x1, y2, c.rl, c.lvl, n);
			if (read_px(mx, my) == 0) begin
				store_px(mx, my, (sum + 2) >> 2);
				n++;
			end
		end
		if (n > 0)
			expected_px[$].last = 1'b1;
	endfunction

	// driver: hold each beat until taken, then wait the drawn gap
	always @(negedge clk) begin
		cmd_beat_t c;
		logic nv;
		nv = 1'b0;
		if (in_valid && !in_taken)
			nv = 1'b1;
		else if (send_gap > 0)
			send_gap--;
		else if (pending_cmds.size() > 0) begin
			c = pending_cmds.pop_front();
			op <= c.op; left_x <= c.lx; top_y <= c.ty; right_x <= c.rx; bottom_y <= c.by;
			depth_level <= c.lvl; rnd_top <= c.rt; rnd_right <= c.rr;
			rnd_bottom <= c.rb; rnd_left <= c.rl; seed_value <= c.seed;
			nv = 1'b1;
			if ($urandom_range(0, 15) == 0)
				send_quiet = !send_quiet;
			send_gap = send_quiet ? 0 : $urandom_range(0, 12);
		end
		in_valid <= nv;
	end

	// receiver: stall a drawn number of cycles before each beat
	always @(negedge clk) begin
		if (out_taken) begin
			if ($urandom_range(0, 15) == 0)
				recv_quiet = !recv_quiet;
			recv_stall = recv_quiet ? 0 : $urandom_range(0, 12);
		end else if (recv_stall > 0)
			recv_stall--;
		out_ready <= (recv_stall == 0);
	end

	// monitor: predict on each command beat, check each pixel beat
	always @(posedge clk) begin
		cmd_beat_t c;
		pix_beat_t e;
		cycles++;
		if (cycles > RUN_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
		in_taken <= in_valid && in_ready;
		out_taken <= out_valid && out_ready;
		if (in_valid && in_ready) begin
			c.op = op; c.lx = left_x; c.ty = top_y; c.rx = right_x; c.by = bottom_y;
			c.lvl = depth_level; c.rt = rnd_top; c.rr = rnd_right;
			c.rb = rnd_bottom; c.rl = rnd_left; c.seed = seed_value;
			predict_writes(c);
		end
		if (out_valid && out_ready) begin
			if (expected_px.size() == 0)
				report($sformatf("unexpected beat (%0d,%0d)=%0d", pixel_x, pixel_y,
					pixel_value));
			else begin
				e = expected_px.pop_front();
				if (pixel_x !== e.x)
					report($sformatf("pixel_x %0d, want %0d", pixel_x, e.x));
				if (pixel_y !== e.y)
					report($sformatf("pixel_y %0d, want %0d", pixel_y, e.y));
				if (pixel_value !== e.v)
					report($sformatf("pixel_value %0d, want %0d at (%0d,%0d)",
						pixel_value, e.v, e.x, e.y));
				if (last_write !== e.last)
					report($sformatf("last_write %0b, want %0b", last_write, e.last));
			end
		end
	end

	task automatic write_reg(input logic [2:0] idx, input int val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[15:0];
		case (idx)
			plsub_pkg::CFG_ROUGHNESS: rough_r = val & 10'h3FF;
			plsub_pkg::CFG_SHIFT:     shift_r = val & 5'h1F;
			plsub_pkg::CFG_CEILING:   ceil_r = val & 16'hFFFF;
			plsub_pkg::CFG_BORDER_EN: bord_en_r = val & 1;
			plsub_pkg::CFG_BORDER_V:  bord_v_r = val & 16'hFFFF;
			plsub_pkg::CFG_WIDTH:     width_r = val & 10'h3FF;
			plsub_pkg::CFG_HEIGHT:    height_r = val & 10'h3FF;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_all(input int r, s, c, be, bv, w, h);
		write_reg(plsub_pkg::CFG_ROUGHNESS, r);
		write_reg(plsub_pkg::CFG_SHIFT, s);
		write_reg(plsub_pkg::CFG_CEILING, c);
		write_reg(plsub_pkg::CFG_BORDER_EN, be);
		write_reg(plsub_pkg::CFG_BORDER_V, bv);
		write_reg(plsub_pkg::CFG_WIDTH, w);
		write_reg(plsub_pkg::CFG_HEIGHT, h);
	endtask

	// hold until all beats are sent and every pixel has come back, then let the
	// block close a command that writes nothing
	task automatic drain;
		while (pending_cmds.size() > 0 || in_valid || expected_px.size() > 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	function automatic cmd_beat_t mk_cmd(int o, lx, ty, rx, by, lvl,
			int rt, rr, rb, rl, sd);
		cmd_beat_t c;
		c.op = o[0]; c.lx = lx[8:0]; c.ty = ty[8:0]; c.rx = rx[8:0]; c.by = by[8:0];
		c.lvl = lvl[3:0]; c.rt = rt[14:0]; c.rr = rr[14:0]; c.rb = rb[14:0];
		c.rl = rl[14:0]; c.seed = sd[15:0];
		return c;
	endfunction

	// mostly small overlapping windows so set midpoints occur; some full-range
	function automatic cmd_beat_t rand_cmd(int base_x, int base_y);
		cmd_beat_t c;
		int span;
		span = ($urandom_range(0, 3) == 0) ? 511 : int'($urandom_range(2, 24));
		c.op = ($urandom_range(0, 9) < 3) ? plsub_pkg::OP_SEED : OP_SPLIT;
		if (span == 511) begin
			c.lx = 9'($urandom); c.ty = 9'($urandom);
			c.rx = 9'($urandom); c.by = 9'($urandom);
		end else begin
			c.lx = 9'(base_x + int'($urandom_range(0, span)));
			c.ty = 9'(base_y + int'($urandom_range(0, span)));
			c.rx = 9'(int'(c.lx) + int'($urandom_range(0, span)));
			c.by = 9'(int'(c.ty) + int'($urandom_range(0, span)));
			if ($urandom_range(0, 9) == 0)
				c.rx = 9'(int'(c.lx) - int'($urandom_range(0, span)));
		end
		c.lvl = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15)) :
			4'($urandom_range(1, 9));
		c.rt = 15'($urandom); c.rr = 15'($urandom);
		c.rb = 15'($urandom); c.rl = 15'($urandom);
		c.seed = ($urandom_range(0, 15) == 0) ? 16'd0 : 16'($urandom);
		return c;
	endfunction

	initial begin
		int bx, by;
		arst_n = 1'b0;
		cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
		rough_r = 0; shift_r = 18; ceil_r = 255; bord_en_r = 0; bord_v_r = 0;
		width_r = 512; height_r = 512;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, border on with a narrow image, zero border value
		set_all(800, 0, 65535, 1, 0, 2, 512);
		pending_cmds.push_back(mk_cmd(plsub_pkg::OP_SEED, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0));
		pending_cmds.push_back(mk_cmd(plsub_pkg::OP_SEED, 511, 511, 0, 0, 1, 0, 0, 0, 0,
			65535));
		pending_cmds.push_back(mk_cmd(plsub_pkg::OP_SEED, 300, 200, 0, 0, 1, 0, 0, 0, 0,
			0));
		pending_cmds.push_back(mk_cmd(OP_SPLIT, 10, 10, 11, 11, 1, 0, 0, 0, 0, 0));
		pending_cmds.push_back(mk_cmd(OP_SPLIT, 0, 0, 511, 511, 1, 0, 32767, 0, 32767, 0));
		pending_cmds.push_back(mk_cmd(OP_SPLIT, 0, 0, 511, 511, 1, 0, 0, 0, 0, 0));
		pending_cmds.push_back(mk_cmd(OP_SPLIT, 100, 100, 40, 140, 9, 32767, 0, 16383,
			1, 0));
		pending_cmds.push_back(mk_cmd(OP_SPLIT, 200, 50, 204, 49, 0, 5, 32767, 7, 0, 0));
		pending_cmds.push_back(mk_cmd(OP_SPLIT, 20, 300, 24, 304, 15, 32767, 32767,
			32767, 32767, 0));
		pending_cmds.push_back(mk_cmd(OP_SPLIT, 1, 1, 2, 5, 2, 0, 0, 0, 0, 0));
		drain();

		// border off, ceiling at its floor, no roughness
		set_all(0, 31, 1, 0, 65535, 512, 2);
		pending_cmds.push_back(mk_cmd(OP_SPLIT, 60, 60, 70, 70, 1, 0, 0, 0, 0, 0));
		pending_cmds.push_back(mk_cmd(OP_SPLIT, 400, 0, 511, 1, 4, 32767, 0, 0, 0, 0));
		pending_cmds.push_back(mk_cmd(plsub_pkg::OP_SEED, 7, 1, 0, 0, 1, 0, 0, 0, 0,
			65535));
		drain();

		// random phases, each with new register settings
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: set_all(0, 18, 255, 0, 0, 512, 512);
				1: set_all(800, 0, 65535, 1, 0, 512, 512);
				2: set_all(800, 31, 1, 1, 65535, 2, 2);
				default: set_all($urandom_range(0, 800), $urandom_range(0, 31),
					$urandom_range(1, 65535), $urandom_range(0, 1), $urandom,
					$urandom_range(2, 512), $urandom_range(2, 512));
			endcase
			for (int i = 0; i < 48; i++) begin
				if (i % 12 == 0) begin
					bx = $urandom_range(0, 460);
					by = $urandom_range(0, 460);
				end
				pending_cmds.push_back(rand_cmd(bx, by));
			end
			drain();
		end

		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule

FILE: sim.f
hw/rtl/plsub_pkg.sv
hw/rtl/plsub_ram.sv
hw/rtl/plsub_ctrl.sv
hw/rtl/plsub_datapath.sv
hw/rtl/plasma_rectangle_subdivide_top.sv
verif/tb_plasma_rectangle_subdivide_top.sv
